### rtl/mlcd_pkg.sv
// Shared constants and types for the marker/length/checksum frame deframer.
// No dependencies; imported by marker_length_checksum_deframer_top.
`default_nettype none

package mlcd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STATUS_W = 3;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h99;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hdd;
    localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd5;
    localparam logic [BYTE_W-1:0] CLIENT_POS = 8'd3;
    localparam logic [BYTE_W-1:0] OWN_CLIENT_ID_RESET = 8'd0;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE      = 3'd0,
        ST_GOOD      = 3'd1,
        ST_BADLEN    = 3'd2,
        ST_BADEND    = 3'd3,
        ST_BADSUM    = 3'd4,
        ST_BADCLIENT = 3'd5
    } status_t;

endpackage : mlcd_pkg

`default_nettype wire

### rtl/marker_length_checksum_deframer_top.sv
// Frame deframer: hunts for start byte, tracks length, checksum, client id and end byte.
// Depends on mlcd_pkg for constants, the phase state type and the status codes.
//
// Usage:
//   s_valid/s_ready/s_rx_byte carry the raw link bytes, one request per byte.
//   m_valid/m_ready carry one result per frame byte: m_frame_byte, m_byte_position,
//   m_frame_end and m_frame_status (nonzero only on the last byte of a frame).
//   Bytes seen while hunting for the start byte 0x99 produce no result.
//   cfg_wr_en/cfg_wr_data write own_client_id at any clock edge with cfg_wr_en high.
// Output: each result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle when not stalled; parser state and result register
//   both update in the accepting cycle, so no byte waits on the one before it.
// Stall: while m_valid is high and m_ready low, s_ready drops and the held result
//   and parser state stay put; s_ready rises in the same cycle m_ready is seen high.
// Reset (aresetn low, synchronous): hunting phase, counters and sums cleared,
//   no result pending, own_client_id back to zero.
`default_nettype none

module marker_length_checksum_deframer_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mlcd_pkg::BYTE_W-1:0] cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mlcd_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mlcd_pkg::BYTE_W-1:0]      m_frame_byte,
    output logic [mlcd_pkg::BYTE_W-1:0]      m_byte_position,
    output logic                             m_frame_end,
    output logic [mlcd_pkg::STATUS_W-1:0]    m_frame_status
);
    import mlcd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]   frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0]   running_sum_reg, running_sum_next;
    logic                sum_matched_reg, sum_matched_next;
    logic                client_matched_reg, client_matched_next;
    logic [BYTE_W-1:0]   own_client_id_reg;

    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   frame_byte_reg, frame_byte_next;
    logic [BYTE_W-1:0]   position_reg, position_next;
    logic                frame_end_reg, frame_end_next;
    status_t             status_reg, status_next;

    logic                accept;
    logic                emit;
    logic [BYTE_W:0]     pos_ext;
    logic [BYTE_W:0]     len_ext;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_ext = {1'b0, byte_count_reg};
    assign len_ext = {1'b0, frame_length_reg};

    always_comb begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        frame_length_next   = frame_length_reg;
        running_sum_next    = running_sum_reg;
        sum_matched_next    = sum_matched_reg;
        client_matched_next = client_matched_reg;
        emit                = 1'b0;
        frame_byte_next     = s_rx_byte;
        position_next       = byte_count_reg;
        frame_end_next      = 1'b0;
        status_next         = ST_NONE;

        case (phase_reg)
            PH_LEN: begin
                frame_length_next = s_rx_byte;
                emit              = 1'b1;
                position_next     = 8'd1;
                if (s_rx_byte < MIN_LENGTH) begin
                    // too short to hold a frame: close it at the length byte
                    phase_next      = PH_HUNT;
                    byte_count_next = '0;
                    frame_end_next  = 1'b1;
                    status_next     = ST_BADLEN;
                end else begin
                    running_sum_next    = s_rx_byte;
                    sum_matched_next    = 1'b0;
                    client_matched_next = 1'b0;
                    byte_count_next     = 8'd2;
                    phase_next          = PH_BODY;
                end
            end
            PH_BODY: begin
                emit = 1'b1;
                if (byte_count_reg == CLIENT_POS) begin
                    client_matched_next = (s_rx_byte == own_client_id_reg);
                end
                if (pos_ext + 9'd2 == len_ext) begin
                    sum_matched_next = (s_rx_byte == running_sum_reg);
                end
                if (pos_ext + 9'd3 <= len_ext) begin
                    running_sum_next = running_sum_reg + s_rx_byte;
                end
                if (pos_ext + 9'd1 >= len_ext) begin
                    phase_next      = PH_HUNT;
                    byte_count_next = '0;
                    frame_end_next  = 1'b1;
                    // end marker first, then checksum, then client
                    if (s_rx_byte != END_BYTE) begin
                        status_next = ST_BADEND;
                    end else if (!sum_matched_next) begin
                        status_next = ST_BADSUM;
                    end else if (!client_matched_next) begin
                        status_next = ST_BADCLIENT;
                    end else begin
                        status_next = ST_GOOD;
                    end
                end else begin
                    byte_count_next = byte_count_reg + 8'd1;
                end
            end
            default: begin
                // hunting, and the unused phase code
                phase_next = PH_HUNT;
                if (s_rx_byte == START_BYTE) begin
                    phase_next      = PH_LEN;
                    byte_count_next = 8'd1;
                    emit            = 1'b1;
                    position_next   = '0;
                end
            end
        endcase

        if (accept) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HUNT;
            byte_count_reg     <= '0;
            frame_length_reg   <= '0;
            running_sum_reg    <= '0;
            sum_matched_reg    <= 1'b0;
            client_matched_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                phase_reg          <= phase_next;
                byte_count_reg     <= byte_count_next;
                frame_length_reg   <= frame_length_next;
                running_sum_reg    <= running_sum_next;
                sum_matched_reg    <= sum_matched_next;
                client_matched_reg <= client_matched_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_client_id_reg <= OWN_CLIENT_ID_RESET;
        end else if (cfg_wr_en) begin
            own_client_id_reg <= cfg_wr_data;
        end
    end

    // result payload: loaded only when a request is taken
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            frame_byte_reg <= frame_byte_next;
            position_reg   <= position_next;
            frame_end_reg  <= frame_end_next;
            status_reg     <= status_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_byte    = frame_byte_reg;
    assign m_byte_position = position_reg;
    assign m_frame_end     = frame_end_reg;
    assign m_frame_status  = status_reg;

endmodule : marker_length_checksum_deframer_top

`default_nettype wire
